// File: rtl/core/shht_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shht_pkg
// shared types and constants of the size histogram table
// ----------------------------------------------------------------------------
package shht_pkg;

  localparam int unsigned TableEntriesDef = 256;
  localparam int unsigned SizeW           = 31;
  localparam int unsigned CountW          = 32;
  localparam int unsigned BytesW          = 64;

  // item travelling down the row of cells
  typedef struct packed {
    logic              active;
    logic              alloc;   // 0: lookup pass, 1: allocation pass
    logic              action;  // 0: allocation, 1: free
    logic [SizeW-1:0]  size;
    logic              hit;
    logic [CountW-1:0] count;
  } shht_tok_t;

endpackage
`default_nettype wire

// File: rtl/core/size_histogram_hash_table_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// size_histogram_hash_table_core
// per-size allocation counter kept in a row of TABLE_ENTRIES-1 entry cells
// ----------------------------------------------------------------------------
// result: the strobe follows one walk of the item down the row when the size
//   is tracked, and a second walk when a new entry is taken or the table is full
// throughput: one item at a time, busy drops with the strobe, so a new item
//   is accepted only after the row walk(s) of the last one are through
// reset: synchronous, clears all entries and totals, no clearing pass
// the receiver cannot stall: out_valid is a one-cycle strobe
module size_histogram_hash_table_core #(
  parameter int unsigned TABLE_ENTRIES = shht_pkg::TableEntriesDef
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           start,
  output logic                          busy,
  input  wire                           in_action,
  input  wire  [shht_pkg::SizeW-1:0]    in_block_size,
  output logic                          out_valid,
  output logic                          out_status,
  output logic signed [shht_pkg::CountW-1:0] out_size_count,
  output logic [shht_pkg::BytesW-1:0]   out_total_bytes,
  output logic signed [shht_pkg::CountW-1:0] out_total_events
);
  import shht_pkg::*;

  // entry zero of the table is never used, so one cell fewer
  localparam int unsigned Cells = TABLE_ENTRIES - 1;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_LOOK  = 2'd1;
  localparam logic [1:0] ST_ALLOC = 2'd2;

  logic [1:0]        state_r, state_nxt;
  shht_tok_t         inj_r, inj_nxt;
  logic              act_r, act_nxt;
  logic [SizeW-1:0]  size_r, size_nxt;
  logic [BytesW-1:0] bytes_r, bytes_nxt;
  logic [CountW-1:0] events_r, events_nxt;
  logic              ov_r, ov_nxt;
  logic              ost_r, ost_nxt;
  logic [CountW-1:0] ocnt_r, ocnt_nxt;

  shht_tok_t tok [0:Cells];
  shht_tok_t tail;

  // row of entry cells, item enters at the head
  assign tok[0] = inj_r;
  for (genvar g = 0; g < Cells; g++) begin : g_cell
    shht_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .tok_i (tok[g]),
      .tok_o (tok[g+1])
    );
  end
  assign tail = tok[Cells];

  always_comb begin
    state_nxt  = state_r;
    inj_nxt    = '0;
    act_nxt    = act_r;
    size_nxt   = size_r;
    bytes_nxt  = bytes_r;
    events_nxt = events_r;
    ov_nxt     = 1'b0;
    ost_nxt    = ost_r;
    ocnt_nxt   = ocnt_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          act_nxt  = in_action;
          size_nxt = in_block_size;
          // totals change on every item, table full or not
          if (in_action) begin
            bytes_nxt  = bytes_r - {{(BytesW-SizeW){1'b0}}, in_block_size};
            events_nxt = events_r - CountW'(1);
          end else begin
            bytes_nxt  = bytes_r + {{(BytesW-SizeW){1'b0}}, in_block_size};
            events_nxt = events_r + CountW'(1);
          end
          inj_nxt.active = 1'b1;
          inj_nxt.alloc  = 1'b0;
          inj_nxt.action = in_action;
          inj_nxt.size   = in_block_size;
          state_nxt      = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (tail.active) begin
          if (tail.hit) begin
            ov_nxt    = 1'b1;
            ost_nxt   = 1'b0;
            ocnt_nxt  = tail.count;
            state_nxt = ST_IDLE;
          end else begin
            // size not tracked: second pass claims the first empty cell
            inj_nxt.active = 1'b1;
            inj_nxt.alloc  = 1'b1;
            inj_nxt.action = act_r;
            inj_nxt.size   = size_r;
            state_nxt      = ST_ALLOC;
          end
        end
      end
      ST_ALLOC: begin
        if (tail.active) begin
          ov_nxt    = 1'b1;
          ost_nxt   = !tail.hit;  // table full
          ocnt_nxt  = tail.hit ? tail.count : '0;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      inj_r    <= '0;
      bytes_r  <= '0;
      events_r <= '0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      inj_r    <= inj_nxt;
      bytes_r  <= bytes_nxt;
      events_r <= events_nxt;
      ov_r     <= ov_nxt;
    end
    act_r  <= act_nxt;
    size_r <= size_nxt;
    ost_r  <= ost_nxt;
    ocnt_r <= ocnt_nxt;
  end

  assign busy             = (state_r != ST_IDLE);
  assign out_valid        = ov_r;
  assign out_status       = ost_r;
  assign out_size_count   = ocnt_r;
  assign out_total_bytes  = bytes_r;
  assign out_total_events = events_r;

endmodule
`default_nettype wire

// File: rtl/core/shht_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shht_cell
// one table entry: holds a size and its count, updates a passing item
// ----------------------------------------------------------------------------
module shht_cell (
  input  wire                 clk,
  input  wire                 rst_n,
  input  shht_pkg::shht_tok_t tok_i,
  output shht_pkg::shht_tok_t tok_o
);
  import shht_pkg::*;

  logic              valid_r, valid_nxt;
  logic [SizeW-1:0]  size_r, size_nxt;
  logic [CountW-1:0] count_r, count_nxt;
  shht_tok_t         tok_r, tok_nxt;
  logic [CountW-1:0] cnt_upd;

  assign cnt_upd = tok_i.action ? (count_r - CountW'(1)) : (count_r + CountW'(1));

  always_comb begin
    tok_nxt   = tok_i;
    valid_nxt = valid_r;
    size_nxt  = size_r;
    count_nxt = count_r;
    if (tok_i.active && !tok_i.hit) begin
      if (!tok_i.alloc) begin
        if (valid_r && (size_r == tok_i.size)) begin
          count_nxt     = cnt_upd;
          valid_nxt     = (cnt_upd != '0);
          tok_nxt.hit   = 1'b1;
          tok_nxt.count = cnt_upd;
        end
      end else if (!valid_r) begin
        valid_nxt     = 1'b1;
        size_nxt      = tok_i.size;
        count_nxt     = tok_i.action ? '1 : CountW'(1);
        tok_nxt.hit   = 1'b1;
        tok_nxt.count = tok_i.action ? '1 : CountW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      tok_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      tok_r   <= tok_nxt;
    end
    size_r  <= size_nxt;
    count_r <= count_nxt;
  end

  assign tok_o = tok_r;

endmodule
`default_nettype wire
